FILE: rtl/led_matrix_i2c_refresh_sequencer_defines.svh
// assertion macros for the led matrix refresh sequencer
// expects clk_i and rst_ni in the scope of use
`ifndef LED_MATRIX_I2C_REFRESH_SEQUENCER_DEFINES_SVH
`define LED_MATRIX_I2C_REFRESH_SEQUENCER_DEFINES_SVH

// condition holds at every rising clock edge out of reset
`define LMX_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// trigger is followed by the condition in the next cycle
`define LMX_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

FILE: rtl/lmx_pkg.sv
// shared types, constants and helpers for the led matrix refresh sequencer
// no dependencies
`default_nettype none

package lmx_pkg;

  localparam int GRID_COLUMNS = 12;
  localparam int GRID_ROWS    = 12;
  localparam int GROUP_BYTES  = 6;

  localparam int PIXELS     = GRID_COLUMNS * GRID_ROWS;
  localparam int GROUPS     = 2 * GRID_ROWS;
  localparam int PIX_AW     = $clog2(PIXELS);
  localparam int PTR_W      = $clog2(PIXELS + GROUP_BYTES + 1);
  localparam int ROW_W      = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int GROUP_W    = ROW_W + 1;
  localparam int BYTES_W    = $clog2(GROUP_BYTES + 1);
  localparam int TMO_W      = 16;
  localparam int TMO_PROD_W = TMO_W + BYTES_W;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] NO_ERROR = 3'd7;

  typedef enum logic [2:0] {
    OP_SET_DUTY  = 3'd0,
    OP_BUS_EVENT = 3'd1,
    OP_BUS_ERROR = 3'd2,
    OP_TICK      = 3'd3,
    OP_BEGIN     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    EV_START_SENT = 2'd0,
    EV_ADDR_ACK   = 2'd1,
    EV_BYTE_DONE  = 2'd2
  } event_e;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_SEND_ADDR = 3'd2,
    CMD_SEND_DATA = 3'd3,
    CMD_STOP      = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_START = 4'b0010,
    PH_ADDR  = 4'b0100,
    PH_DATA  = 4'b1000
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEVICE_ADDR  = 4'd0,
    CFG_DUTY_BASE    = 4'd1,
    CFG_TMO_RELOAD   = 4'd2,
    CFG_AUTO_REFRESH = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [3:0] column;
    logic [3:0] row;
    logic [7:0] duty;
    logic [1:0] event_kind;
    logic [2:0] error_kind;
  } in_item_t;

  typedef struct packed {
    logic [2:0] bus_command;
    logic [7:0] bus_byte;
    logic       error_pending;
    logic [2:0] error_code;
    logic       timed_out;
    logic       last;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [7:0] group_register(logic [GROUP_W-1:0] g, logic [7:0] base);
    logic [7:0] row_off;
    row_off = 8'({g[GROUP_W-1:1], 4'b0000});
    return base + row_off + (g[0] ? 8'd8 : 8'd0);
  endfunction

  function automatic logic [GROUP_W-1:0] next_group(logic [GROUP_W-1:0] g);
    return (g == GROUP_W'(GROUPS - 1)) ? '0 : g + GROUP_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] pixel_index(logic [GROUP_W-1:0] g,
                                                   logic [BYTES_W-1:0] bs);
    return PTR_W'(g[GROUP_W-1:1]) * PTR_W'(GRID_COLUMNS)
         + (g[0] ? PTR_W'(GROUP_BYTES) : '0) + PTR_W'(bs);
  endfunction

  function automatic logic [PTR_W-1:0] pixel_addr(logic [3:0] row, logic [3:0] col);
    return PTR_W'(row) * PTR_W'(GRID_COLUMNS) + PTR_W'(col);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lmx_if.sv
// valid/ready channels of the led matrix refresh sequencer
// depends on lmx_pkg
`default_nettype none

interface lmx_in_if;
  logic              valid;
  logic              ready;
  lmx_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lmx_out_if;
  logic             valid;
  logic             ready;
  lmx_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lmx_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lmx_pkg::CFG_IDX_W-1:0]  index;
  logic [lmx_pkg::CFG_DATA_W-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: rtl/lmx_frame_store.sv
// frame buffer memory with per-pixel valid flags and registered read
// depends on lmx_pkg
`default_nettype none

module lmx_frame_store (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire lmx_pkg::store_wr_t        wr_i,
  input  wire logic [lmx_pkg::PTR_W-1:0] rd_addr_i,
  output logic [7:0]                     rd_data_o
);

  logic [7:0]                   mem [lmx_pkg::PIXELS];
  logic [lmx_pkg::PIXELS-1:0]   vld_q;
  logic [7:0]                   raw_q;
  logic [7:0]                   byp_data_q;
  logic                         byp_q;
  logic                         hit_q;
  logic                         in_range;
  logic [lmx_pkg::PIX_AW-1:0]   rd_idx;
  logic [lmx_pkg::PIX_AW-1:0]   wr_idx;

  assign in_range = rd_addr_i < lmx_pkg::PIXELS;
  assign rd_idx   = rd_addr_i[lmx_pkg::PIX_AW-1:0];
  assign wr_idx   = wr_i.addr[lmx_pkg::PIX_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_idx] <= wr_i.data;
    end
    raw_q      <= mem[rd_idx];
    byp_data_q <= wr_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      byp_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        vld_q[wr_idx] <= 1'b1;
      end
      byp_q <= wr_i.we && (wr_i.addr == rd_addr_i);
      hit_q <= in_range ? vld_q[rd_idx] : 1'b0;
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : (hit_q ? raw_q : 8'd0);

endmodule

`default_nettype wire

FILE: rtl/lmx_result_queue.sv
// four-entry result queue, takes up to two items per cycle and sends one while the output is ready
// depends on lmx_pkg and lmx_if
`default_nettype none

module lmx_result_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire lmx_pkg::push_t push_i,
  output logic                space_o,
  lmx_out_if.source           out_if
);

  lmx_pkg::result_t             entry_q [lmx_pkg::QUEUE_DEPTH];
  logic [lmx_pkg::QPTR_W-1:0]   wr_q;
  logic [lmx_pkg::QPTR_W-1:0]   rd_q;
  logic [lmx_pkg::QCNT_W-1:0]   cnt_q;
  logic [lmx_pkg::QPTR_W-1:0]   wr_next;
  logic                         pop;

  assign pop          = out_if.valid && out_if.ready;
  assign out_if.valid = cnt_q != '0;
  assign out_if.data  = entry_q[rd_q];
  assign space_o      = cnt_q <= lmx_pkg::QCNT_W'(lmx_pkg::QUEUE_DEPTH - 2);
  assign wr_next      = wr_q + lmx_pkg::QPTR_W'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      entry_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      entry_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + lmx_pkg::QPTR_W'(push_i.count);
      rd_q  <= rd_q + lmx_pkg::QPTR_W'(pop);
      cnt_q <= cnt_q + lmx_pkg::QCNT_W'(push_i.count) - lmx_pkg::QCNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/led_matrix_i2c_refresh_sequencer.sv
// Refresh sequencer for a 12x12 LED matrix on an I2C LED driver. Items enter an
// input register and are handled from there once the result queue has room; their
// one or two results are written into a four-entry queue, whose registered
// entries drive the result port. One item is taken per cycle for as long as each
// item gives one result and the result port stays ready; an item that gives two
// (stop then start) holds the rate to the result port's one result per cycle, as
// the queue admits an item only with two free entries.
// The frame buffer is a 144-entry memory with one valid flag per pixel, cleared
// at once by reset, so no clearing pass follows reset. Configuration writes
// are always accepted.
// depends on lmx_pkg, lmx_if, lmx_frame_store, lmx_result_queue and the defines header
`default_nettype none

`include "led_matrix_i2c_refresh_sequencer_defines.svh"

module led_matrix_i2c_refresh_sequencer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lmx_in_if.sink    in_if,
  lmx_out_if.source out_if,
  lmx_cfg_if.sink   cfg_if
);

  // configuration
  logic [7:0]               dev_addr_q;
  logic [7:0]               duty_base_q;
  logic [lmx_pkg::TMO_W-1:0] tmo_reload_q;
  logic                     auto_refresh_q;

  // input register
  lmx_pkg::in_item_t in_q;
  logic              in_vld_q;

  // sequencer state
  lmx_pkg::phase_e              phase_q, phase_d;
  logic [lmx_pkg::GROUP_W-1:0]  gs_q, gs_d;
  logic [lmx_pkg::BYTES_W-1:0]  bs_q, bs_d;
  logic [7:0]                   tgt_q, tgt_d;
  logic [lmx_pkg::TMO_W-1:0]    tc_q, tc_d;
  logic [2:0]                   err_q, err_d;

  logic                            fire;
  logic                            space;
  logic [7:0]                      rd_data;
  logic [lmx_pkg::PTR_W-1:0]       rd_ptr;
  lmx_pkg::store_wr_t              store_wr;
  lmx_pkg::push_t                  push;
  logic [lmx_pkg::TMO_PROD_W-1:0]  tmo_prod;
  logic [lmx_pkg::TMO_W-1:0]       tmo_sat;
  lmx_pkg::cmd_e                   cmd0, cmd1;
  logic [7:0]                      byte0;
  logic [1:0]                      n_res;

  assign fire        = in_vld_q && space;
  assign in_if.ready = !in_vld_q || fire;
  assign cfg_if.ready = 1'b1;

  assign tmo_prod = lmx_pkg::TMO_PROD_W'(tmo_reload_q)
                  * lmx_pkg::TMO_PROD_W'(lmx_pkg::GROUP_BYTES);
  assign tmo_sat  = (|tmo_prod[lmx_pkg::TMO_PROD_W-1:lmx_pkg::TMO_W]) ?
                    '1 : tmo_prod[lmx_pkg::TMO_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q     <= 8'd160;
      duty_base_q    <= 8'd0;
      tmo_reload_q   <= 16'd200;
      auto_refresh_q <= 1'b1;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        lmx_pkg::CFG_DEVICE_ADDR:  dev_addr_q     <= cfg_if.wdata[7:0];
        lmx_pkg::CFG_DUTY_BASE:    duty_base_q    <= cfg_if.wdata[7:0];
        lmx_pkg::CFG_TMO_RELOAD:   tmo_reload_q   <= cfg_if.wdata[lmx_pkg::TMO_W-1:0];
        lmx_pkg::CFG_AUTO_REFRESH: auto_refresh_q <= cfg_if.wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_q <= in_if.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      phase_q  <= lmx_pkg::PH_IDLE;
      gs_q     <= '0;
      bs_q     <= '0;
      tgt_q    <= '0;
      tc_q     <= '0;
      err_q    <= lmx_pkg::NO_ERROR;
    end else begin
      in_vld_q <= in_if.valid || (in_vld_q && !fire);
      phase_q  <= phase_d;
      gs_q     <= gs_d;
      bs_q     <= bs_d;
      tgt_q    <= tgt_d;
      tc_q     <= tc_d;
      err_q    <= err_d;
    end
  end

  always_comb begin
    lmx_pkg::phase_e          ph_tmp;
    logic [lmx_pkg::TMO_W-1:0] tc_tmp;
    phase_d  = phase_q;
    gs_d     = gs_q;
    bs_d     = bs_q;
    tgt_d    = tgt_q;
    tc_d     = tc_q;
    err_d    = err_q;
    cmd0     = lmx_pkg::CMD_NONE;
    cmd1     = lmx_pkg::CMD_NONE;
    byte0    = 8'd0;
    n_res    = 2'd0;
    store_wr = '0;
    ph_tmp   = phase_q;
    tc_tmp   = tc_q;
    if (fire) begin
      case (in_q.operation)
        lmx_pkg::OP_SET_DUTY: begin
          if (in_q.column < lmx_pkg::GRID_COLUMNS && in_q.row < lmx_pkg::GRID_ROWS) begin
            store_wr.we   = 1'b1;
            store_wr.addr = lmx_pkg::pixel_addr(in_q.row, in_q.column);
            store_wr.data = in_q.duty;
          end
        end
        lmx_pkg::OP_BUS_EVENT: begin
          tc_d = tmo_reload_q;
          if (phase_q == lmx_pkg::PH_START && in_q.event_kind == lmx_pkg::EV_START_SENT) begin
            phase_d = lmx_pkg::PH_ADDR;
            cmd0    = lmx_pkg::CMD_SEND_ADDR;
            byte0   = dev_addr_q;
            n_res   = 2'd1;
          end else if (phase_q == lmx_pkg::PH_ADDR
                       && in_q.event_kind == lmx_pkg::EV_ADDR_ACK) begin
            phase_d = lmx_pkg::PH_DATA;
            cmd0    = lmx_pkg::CMD_SEND_DATA;
            byte0   = tgt_q;
            n_res   = 2'd1;
          end else if (phase_q == lmx_pkg::PH_DATA
                       && in_q.event_kind == lmx_pkg::EV_BYTE_DONE) begin
            if (bs_q < lmx_pkg::GROUP_BYTES) begin
              cmd0  = lmx_pkg::CMD_SEND_DATA;
              byte0 = rd_data;
              bs_d  = bs_q + lmx_pkg::BYTES_W'(1);
              n_res = 2'd1;
            end else begin
              phase_d = lmx_pkg::PH_IDLE;
              cmd0    = lmx_pkg::CMD_STOP;
              n_res   = 2'd1;
              if (auto_refresh_q) begin
                gs_d    = lmx_pkg::next_group(gs_q);
                tgt_d   = lmx_pkg::group_register(gs_d, duty_base_q);
                bs_d    = '0;
                phase_d = lmx_pkg::PH_START;
                cmd1    = lmx_pkg::CMD_START;
                n_res   = 2'd2;
              end
            end
          end
        end
        lmx_pkg::OP_BUS_ERROR: begin
          if (err_q == lmx_pkg::NO_ERROR && in_q.error_kind != lmx_pkg::NO_ERROR) begin
            err_d = in_q.error_kind;
          end
        end
        lmx_pkg::OP_TICK: begin
          if (tc_q != '0) begin
            tc_d = tc_q - lmx_pkg::TMO_W'(1);
          end
        end
        lmx_pkg::OP_BEGIN: begin
          if (err_q != lmx_pkg::NO_ERROR) begin
            tc_tmp = '0;
            ph_tmp = lmx_pkg::PH_IDLE;
            err_d  = lmx_pkg::NO_ERROR;
            cmd0   = lmx_pkg::CMD_STOP;
            n_res  = 2'd1;
          end
          tc_d    = tc_tmp;
          phase_d = ph_tmp;
          if (ph_tmp == lmx_pkg::PH_IDLE || tc_tmp == '0) begin
            gs_d    = '0;
            tgt_d   = lmx_pkg::group_register('0, duty_base_q);
            bs_d    = '0;
            phase_d = lmx_pkg::PH_START;
            tc_d    = tmo_sat;
            if (n_res == 2'd0) begin
              cmd0 = lmx_pkg::CMD_START;
            end else begin
              cmd1 = lmx_pkg::CMD_START;
            end
            n_res = n_res + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    push.first.bus_command   = cmd0;
    push.first.bus_byte      = byte0;
    push.first.error_pending = err_d != lmx_pkg::NO_ERROR;
    push.first.error_code    = err_d;
    push.first.timed_out     = (tc_d == '0) && (phase_d != lmx_pkg::PH_IDLE);
    push.first.last          = n_res != 2'd2;
    push.second              = push.first;
    push.second.bus_command  = cmd1;
    push.second.bus_byte     = 8'd0;
    push.second.last         = 1'b1;
    if (!fire) begin
      push.count = 2'd0;
    end else if (n_res == 2'd2) begin
      push.count = 2'd2;
    end else begin
      push.count = 2'd1;
    end
  end

  // read follows the next byte position, so the data is ready for the next item
  assign rd_ptr = lmx_pkg::pixel_index(gs_d, bs_d);

  lmx_frame_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (store_wr),
    .rd_addr_i (rd_ptr),
    .rd_data_o (rd_data)
  );

  lmx_result_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .out_if  (out_if)
  );

  `LMX_ASSERT_HOLDS(a_group_range, gs_q < lmx_pkg::GROUPS, "group number out of range")
  `LMX_ASSERT_HOLDS(a_bytes_range, bs_q <= lmx_pkg::GROUP_BYTES, "byte count past group")
  `LMX_ASSERT_NEXT(a_begin_recovers,
    fire && in_q.operation == lmx_pkg::OP_BEGIN && err_q != lmx_pkg::NO_ERROR,
    err_q == lmx_pkg::NO_ERROR && phase_q == lmx_pkg::PH_START,
    "begin refresh did not recover from latched error")
  `LMX_ASSERT_NEXT(a_result_queued, fire, out_if.valid, "handled item left no result")

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the led matrix refresh sequencer: directed rows, then
// random bus traffic over four phases of varied input idling and result stalls, checked against a cycle-free predictor
// depends on lmx_pkg, the lmx channel interfaces and led_matrix_i2c_refresh_sequencer

module tb_top;
  import lmx_pkg::*;

  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         HOLD_CYCLES  = 60;
  localparam int         MAX_SHOWN    = 10;
  localparam logic [2:0] OP_RESERVED  = 3'd6;
  localparam logic [1:0] EV_RESERVED  = 2'd3;
  localparam logic [2:0] ERR_NACK     = 3'd2;
  localparam logic [2:0] ERR_TIMEOUT  = 3'd5;
  localparam logic [3:0] CFG_UNUSED   = 4'd9;

  typedef struct {
    in_item_t stim;
    int       n_typed;
    result_t  typed0;
    result_t  typed1;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lmx_in_if  in_ch ();
  lmx_out_if out_ch ();
  lmx_cfg_if cfg_ch ();

  led_matrix_i2c_refresh_sequencer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #1 clk_i = ~clk_i;

  // predicted sequencer state and settings
  logic [7:0]  frame_copy [PIXELS] = '{default: 8'h00};
  int          grp = 0;
  int          nbytes = 0;
  phase_e      phase = PH_IDLE;
  logic [7:0]  reg_byte = 8'h00;
  logic [15:0] tmo = 16'h0000;
  logic [2:0]  err_latch = NO_ERROR;
  logic [7:0]  dev_addr = 8'd160;
  logic [7:0]  duty_base = 8'h00;
  logic [15:0] tmo_reload = 16'd200;
  logic        auto_on = 1'b1;

  result_t  due_results [$];
  result_t  typed_exp [2];
  int       typed_n = 0;
  dir_row_t dir_tab [$];

  int cycle_count = 0;
  int fails = 0;
  int items_taken = 0;
  int results_checked = 0;
  int frame_wraps = 0;
  int error_latches = 0;
  int timeout_restarts = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;

  function automatic logic [7:0] group_reg(int g);
    return duty_base + 8'(g / 2 * 16) + 8'(g % 2 * 8);
  endfunction

  task automatic advance_sequencer(input in_item_t it, output result_t outs [2],
                                   output int n);
    cmd_e       cmd [2];
    logic [7:0] byt [2];
    int         pix;
    int         prod;
    n = 0;
    cmd[0] = CMD_NONE;
    cmd[1] = CMD_NONE;
    byt[0] = 8'h00;
    byt[1] = 8'h00;
    case (it.operation)
      OP_SET_DUTY: begin
        if (it.column < GRID_COLUMNS && it.row < GRID_ROWS)
          frame_copy[int'(it.row) * GRID_COLUMNS + int'(it.column)] = it.duty;
      end
      OP_BUS_EVENT: begin
        tmo = tmo_reload;
        if (phase == PH_START && it.event_kind == EV_START_SENT) begin
          phase = PH_ADDR;
          cmd[n] = CMD_SEND_ADDR;
          byt[n] = dev_addr;
          n++;
        end else if (phase == PH_ADDR && it.event_kind == EV_ADDR_ACK) begin
          phase = PH_DATA;
          cmd[n] = CMD_SEND_DATA;
          byt[n] = reg_byte;
          n++;
        end else if (phase == PH_DATA && it.event_kind == EV_BYTE_DONE) begin
          if (nbytes < GROUP_BYTES) begin
            pix = (grp / 2) * GRID_COLUMNS + (grp % 2) * GROUP_BYTES + nbytes;
            cmd[n] = CMD_SEND_DATA;
            byt[n] = (pix < PIXELS) ? frame_copy[pix] : 8'h00;
            n++;
            nbytes++;
          end else begin
            phase = PH_IDLE;
            cmd[n] = CMD_STOP;
            n++;
            if (auto_on) begin
              grp = (grp + 1 >= GROUPS) ? 0 : grp + 1;
              if (grp == 0) frame_wraps++;
              reg_byte = group_reg(grp);
              nbytes = 0;
              phase = PH_START;
              tmo = tmo_reload;
              cmd[n] = CMD_START;
              n++;
            end
          end
        end
      end
      OP_BUS_ERROR: begin
        if (err_latch == NO_ERROR && it.error_kind != NO_ERROR) begin
          err_latch = it.error_kind;
          error_latches++;
        end
      end
      OP_TICK: begin
        if (tmo != 16'h0000) tmo = tmo - 16'd1;
      end
      OP_BEGIN: begin
        if (err_latch != NO_ERROR) begin
          tmo = 16'h0000;
          phase = PH_IDLE;
          err_latch = NO_ERROR;
          cmd[n] = CMD_STOP;
          n++;
        end else if (phase != PH_IDLE && tmo == 16'h0000) begin
          timeout_restarts++;
        end
        if (phase == PH_IDLE || tmo == 16'h0000) begin
          prod = int'(tmo_reload) * GROUP_BYTES;
          grp = 0;
          reg_byte = group_reg(0);
          nbytes = 0;
          phase = PH_START;
          tmo = (prod > 65535) ? 16'hFFFF : 16'(prod);
          cmd[n] = CMD_START;
          n++;
        end
      end
      default: ;
    endcase
    if (n == 0) n = 1;
    for (int k = 0; k < n; k++) begin
      outs[k].bus_command   = cmd[k];
      outs[k].bus_byte      = (cmd[k] == CMD_SEND_ADDR || cmd[k] == CMD_SEND_DATA) ?
                              byt[k] : 8'h00;
      outs[k].error_pending = (err_latch != NO_ERROR);
      outs[k].error_code    = err_latch;
      outs[k].timed_out     = (tmo == 16'h0000 && phase != PH_IDLE);
      outs[k].last          = (k == n - 1);
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    results_checked++;
    if (due_results.size() == 0) begin
      fails++;
      if (fails <= MAX_SHOWN)
        $display("cycle %0d: unexpected result cmd %0d byte %02h pend %0b code %0d tmo %0b last %0b",
                 cycle_count, got.bus_command, got.bus_byte, got.error_pending,
                 got.error_code, got.timed_out, got.last);
      return;
    end
    want = due_results.pop_front();
    if (got.bus_command !== want.bus_command || got.bus_byte !== want.bus_byte ||
        got.error_pending !== want.error_pending || got.error_code !== want.error_code ||
        got.timed_out !== want.timed_out || got.last !== want.last) begin
      fails++;
      if (fails <= MAX_SHOWN) begin
        $display("cycle %0d: expected cmd %0d byte %02h pend %0b code %0d tmo %0b last %0b",
                 cycle_count, want.bus_command, want.bus_byte, want.error_pending,
                 want.error_code, want.timed_out, want.last);
        $display("cycle %0d:      got cmd %0d byte %02h pend %0b code %0d tmo %0b last %0b",
                 cycle_count, got.bus_command, got.bus_byte, got.error_pending,
                 got.error_code, got.timed_out, got.last);
      end
    end
  endtask

  // sample both channels and the register port on the rising edge
  always @(posedge clk_i) begin : watch
    result_t outs [2];
    int      n;
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_DEVICE_ADDR:  dev_addr = cfg_ch.wdata[7:0];
          CFG_DUTY_BASE:    duty_base = cfg_ch.wdata[7:0];
          CFG_TMO_RELOAD:   tmo_reload = cfg_ch.wdata;
          CFG_AUTO_REFRESH: auto_on = cfg_ch.wdata[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        items_taken++;
        advance_sequencer(in_ch.data, outs, n);
        if (typed_n != 0)
          for (int k = 0; k < typed_n; k++) due_results.push_back(typed_exp[k]);
        else
          for (int k = 0; k < n; k++) due_results.push_back(outs[k]);
      end
      if (out_ch.valid && out_ch.ready) check_result(out_ch.data);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped at cycle %0d with %0d results outstanding", cycle_count,
               due_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls plus requested long hold-offs
  initial begin : result_side
    int hold_left;
    int hold_served;
    hold_left = 0;
    hold_served = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= rst_ni && ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic in_item_t pack_item(logic [2:0] op, logic [3:0] col, logic [3:0] rw,
                                         logic [7:0] duty, logic [1:0] ev, logic [2:0] ek);
    in_item_t it;
    it.operation  = op;
    it.column     = col;
    it.row        = rw;
    it.duty       = duty;
    it.event_kind = ev;
    it.error_kind = ek;
    return it;
  endfunction

  function automatic result_t res(cmd_e c, logic [7:0] b, logic p, logic [2:0] code,
                                  logic to, logic l);
    result_t r;
    r.bus_command   = c;
    r.bus_byte      = b;
    r.error_pending = p;
    r.error_code    = code;
    r.timed_out     = to;
    r.last          = l;
    return r;
  endfunction

  // mostly well-formed traffic that follows the predicted bus phase
  function automatic in_item_t next_stimulus(bit clean);
    in_item_t it;
    int       pick;
    it = $bits(in_item_t)'($urandom);
    pick = $urandom_range(999);
    if (!clean && pick < 60) return it;
    if (pick < (clean ? 50 : 180)) begin
      it.operation = OP_SET_DUTY;
      it.column = 4'($urandom_range(GRID_COLUMNS - 1));
      it.row = 4'($urandom_range(GRID_ROWS - 1));
    end else if (!clean && pick < 330) begin
      it.operation = OP_TICK;
    end else if (!clean && pick < 338) begin
      it.operation = OP_BUS_ERROR;
    end else if ((phase == PH_IDLE && $urandom_range(4) != 0) ||
                 (!clean && err_latch != NO_ERROR && $urandom_range(29) == 0) ||
                 (!clean && tmo == 16'h0000 && $urandom_range(19) == 0)) begin
      it.operation = OP_BEGIN;
    end else begin
      it.operation = OP_BUS_EVENT;
      if ($urandom_range(99) < 92)
        case (phase)
          PH_START: it.event_kind = EV_START_SENT;
          PH_ADDR:  it.event_kind = EV_ADDR_ACK;
          PH_DATA:  it.event_kind = EV_BYTE_DONE;
          default: ;
        endcase
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  initial begin : stimulus
    result_t quiet;
    result_t stop_r;
    result_t start_r;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.wdata = '0;
    quiet = res(CMD_NONE, 8'h00, 1'b0, NO_ERROR, 1'b0, 1'b1);
    stop_r = res(CMD_STOP, 8'h00, 1'b0, NO_ERROR, 1'b0, 1'b0);
    start_r = res(CMD_START, 8'h00, 1'b0, NO_ERROR, 1'b0, 1'b1);

    dir_tab.push_back('{pack_item(OP_TICK, 0, 0, 0, 0, 0), 1, quiet, quiet});
    dir_tab.push_back('{pack_item(OP_SET_DUTY, 0, 0, 8'hFF, 0, 0), 1, quiet, quiet});
    dir_tab.push_back('{pack_item(OP_SET_DUTY, 11, 11, 8'h81, 0, 0), 1, quiet, quiet});
    dir_tab.push_back('{pack_item(OP_SET_DUTY, 15, 15, 8'h7E, 0, 0), 1, quiet, quiet});
    dir_tab.push_back('{pack_item(OP_SET_DUTY, 5, 0, 8'h5A, 0, 0), 0, quiet, quiet});
    dir_tab.push_back('{pack_item(OP_SET_DUTY, 6, 0, 8'h3C, 0, 0), 0, quiet, quiet});
    dir_tab.push_back('{pack_item(OP_BUS_EVENT, 0, 0, 0, EV_START_SENT, 0), 1, quiet, quiet});
    dir_tab.push_back('{pack_item(OP_RESERVED, 0, 0, 0, 0, 0), 1, quiet, quiet});
    dir_tab.push_back('{pack_item(OP_BEGIN, 0, 0, 0, 0, 0), 1, start_r, quiet});
    dir_tab.push_back('{pack_item(OP_BUS_EVENT, 0, 0, 0, EV_ADDR_ACK, 0), 1, quiet, quiet});
    dir_tab.push_back('{pack_item(OP_BUS_EVENT, 0, 0, 0, EV_START_SENT, 0), 1,
                        res(CMD_SEND_ADDR, 8'd160, 1'b0, NO_ERROR, 1'b0, 1'b1), quiet});
    dir_tab.push_back('{pack_item(OP_BUS_EVENT, 0, 0, 0, EV_ADDR_ACK, 0), 1,
                        res(CMD_SEND_DATA, 8'h00, 1'b0, NO_ERROR, 1'b0, 1'b1), quiet});
    repeat (GROUP_BYTES)
      dir_tab.push_back('{pack_item(OP_BUS_EVENT, 0, 0, 0, EV_BYTE_DONE, 0), 0, quiet, quiet});
    dir_tab.push_back('{pack_item(OP_BUS_EVENT, 0, 0, 0, EV_BYTE_DONE, 0), 2, stop_r, start_r});
    dir_tab.push_back('{pack_item(OP_BUS_EVENT, 0, 0, 0, EV_RESERVED, 0), 0, quiet, quiet});
    dir_tab.push_back('{pack_item(OP_BUS_ERROR, 0, 0, 0, 0, ERR_NACK), 1,
                        res(CMD_NONE, 8'h00, 1'b1, ERR_NACK, 1'b0, 1'b1), quiet});
    dir_tab.push_back('{pack_item(OP_BUS_ERROR, 0, 0, 0, 0, ERR_TIMEOUT), 1,
                        res(CMD_NONE, 8'h00, 1'b1, ERR_NACK, 1'b0, 1'b1), quiet});
    dir_tab.push_back('{pack_item(OP_BEGIN, 0, 0, 0, 0, 0), 2, stop_r, start_r});
    dir_tab.push_back('{pack_item(OP_BUS_ERROR, 0, 0, 0, 0, NO_ERROR), 1, quiet, quiet});
    dir_tab.push_back('{pack_item(OP_BEGIN, 0, 0, 0, 0, 0), 1, quiet, quiet});

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      typed_n = dir_tab[i].n_typed;
      typed_exp[0] = dir_tab[i].typed0;
      typed_exp[1] = dir_tab[i].typed1;
      send_item(dir_tab[i].stim);
    end
    typed_n = 0;

    for (int p = 0; p < 4; p++) begin
      if (p != 0) begin
        settle();
        case (p)
          1: begin
            write_reg(CFG_DEVICE_ADDR, 16'h00FF);
            write_reg(CFG_DUTY_BASE, 16'h00F8);
            write_reg(CFG_TMO_RELOAD, 16'hFFFF);
            write_reg(CFG_AUTO_REFRESH, 16'h0001);
            write_reg(CFG_UNUSED, 16'($urandom));
          end
          2: begin
            write_reg(CFG_DEVICE_ADDR, 16'h0000);
            write_reg(CFG_DUTY_BASE, 16'h0000);
            write_reg(CFG_TMO_RELOAD, 16'd2);
            write_reg(CFG_AUTO_REFRESH, 16'hFFFE);
          end
          default: begin
            write_reg(CFG_DEVICE_ADDR, 16'($urandom));
            write_reg(CFG_DUTY_BASE, 16'h0055);
            write_reg(CFG_TMO_RELOAD, 16'd0);
            write_reg(CFG_AUTO_REFRESH, 16'h0001);
          end
        endcase
        cfg_ch.valid <= 1'b0;
      end
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 45; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 45; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      for (int i = 0; i < (p == 0 ? 250 : 175); i++) begin
        if (i == 50) hold_requests++;
        send_item(next_stimulus(p == 0));
      end
    end

    settle();
    fails += due_results.size();
    $display("%0d items sent through four idling phases, %0d results compared",
             items_taken, results_checked);
    $display("frame wraps %0d, errors latched %0d, restarts after timeout %0d, failures %0d",
             frame_wraps, error_latches, timeout_restarts, fails);
    if (fails == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
